// ===== hdl/ica_pkg.sv =====
// Shared types, constants and the arctangent table of the attitude estimator.
package ica_pkg;

    localparam int STEP_W     = 5;
    localparam int ROOT_STEPS = 24;
    localparam int LANE_W     = 28;
    localparam int ANG_W      = 26;
    localparam int TRACK_W    = 26;
    localparam int PROD_W     = 53;
    localparam int PRED_W     = 35;
    localparam int MIX_W      = 54;
    localparam int YAW_W      = 34;

    localparam logic [15:0] GYRO_WEIGHT_RESET   = 16'd62915;
    localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd655;
    localparam logic signed [YAW_W-1:0] YAW_MODULUS = 34'sd3019898880;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;

    localparam logic REG_GYRO_WEIGHT   = 1'b0;
    localparam logic REG_SAMPLE_PERIOD = 1'b1;

    localparam logic AXIS_ROLL  = 1'b0;
    localparam logic AXIS_PITCH = 1'b1;

    // atan(2^-i) in degrees, Q16
    localparam logic [21:0] ATAN_TABLE [0:23] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SQ_A, OP_SQ_B, OP_ROOT, OP_CINIT, OP_CORDIC,
        OP_RATE, OP_PRED, OP_MULW, OP_MULA, OP_MIX, OP_YRATE, OP_YAW, OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_A, ST_SQ_B, ST_ROOT, ST_CINIT, ST_CORDIC, ST_RATE,
        ST_PRED, ST_MULW, ST_MULA, ST_MIX, ST_YRATE, ST_YAW, ST_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic              axis;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } lane_t;

endpackage

// ===== hdl/imu_complementary_attitude.sv =====
// Top level of the complementary-filter attitude estimator.
// Usage:
// One six-axis sample enters as a word on the s_ channel; one word with filtered
// roll, filtered pitch and integrated yaw leaves on the m_ channel for each sample.
// Roll and pitch from the accelerometer come from a CORDIC arctangent, the pitch
// denominator from a bit-serial square root, and they are blended with the
// gyro-propagated previous angles by the gyro_weight register.
// From acceptance to the result, each sample runs the squaring of accel_y and
// accel_z, 24 root steps, a pre-rotation, the CORDIC iterations, then per axis
// the rate, prediction, weight multiply, angle multiply and blend on the one
// shared multiplier, the yaw rate and update, and the output register load.
// The sequencer takes one sample at a time and returns to idle before it
// takes the next, so no new sample is taken until the last one is through.
// s_tready is high only while the sequencer is idle. A finished result sits in
// an output register; if the receiver stalls, the next sample is still
// accepted and computed, and it waits at its end until the register is free.
// Reset clears the angle tracks, the output valid and loads the register
// defaults. Configuration should be written only while the block is idle.
module imu_complementary_attitude #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_angle [17:0], pitch_angle [35:18], yaw_angle [52:36], zero fill
    output logic [55:0] m_tdata
);

    ica_pkg::cmd_t    cmd;
    ica_pkg::status_t dp_status, ctrl_status;

    // The sequencer sees the input valid together with the output slot state.
    assign ctrl_status.in_valid = s_tvalid;
    assign ctrl_status.out_free = dp_status.out_free;

    ica_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .status (ctrl_status),
        .cmd    (cmd),
        .ready  (s_tready)
    );

    ica_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (dp_status),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // Once a word is taken, the sequencer is busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a sample is in work");

    // Yaw always lies below 360 degrees.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[52:36] < 17'd92160))
        else $error("yaw out of range");

    // A result never appears straight after a sample is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared straight after acceptance");
`endif

endmodule

// ===== hdl/ica_ctrl.sv =====
// Sequencer of the attitude estimator: steps the datapath through one sample.
module ica_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ica_pkg::status_t status,
    output ica_pkg::cmd_t    cmd,
    output logic             ready
);

    ica_pkg::state_t state_reg, state_next;
    logic [ica_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ica_pkg::ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= ica_pkg::AXIS_ROLL;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd.op     = ica_pkg::OP_NONE;
        cmd.axis   = axis_reg;
        cmd.step   = cnt_reg;
        ready      = 1'b0;
        case (state_reg)
            ica_pkg::ST_IDLE: begin
                ready = 1'b1;
                if (status.in_valid) begin
                    cmd.op     = ica_pkg::OP_LOAD;
                    state_next = ica_pkg::ST_SQ_A;
                end
            end
            ica_pkg::ST_SQ_A: begin
                cmd.op     = ica_pkg::OP_SQ_A;
                state_next = ica_pkg::ST_SQ_B;
            end
            ica_pkg::ST_SQ_B: begin
                cmd.op     = ica_pkg::OP_SQ_B;
                cnt_next   = '0;
                state_next = ica_pkg::ST_ROOT;
            end
            ica_pkg::ST_ROOT: begin
                cmd.op   = ica_pkg::OP_ROOT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ica_pkg::STEP_W'(ica_pkg::ROOT_STEPS - 1)) begin
                    state_next = ica_pkg::ST_CINIT;
                end
            end
            ica_pkg::ST_CINIT: begin
                cmd.op     = ica_pkg::OP_CINIT;
                cnt_next   = '0;
                state_next = ica_pkg::ST_CORDIC;
            end
            ica_pkg::ST_CORDIC: begin
                cmd.op   = ica_pkg::OP_CORDIC;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ica_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
                    axis_next  = ica_pkg::AXIS_ROLL;
                    state_next = ica_pkg::ST_RATE;
                end
            end
            ica_pkg::ST_RATE: begin
                cmd.op     = ica_pkg::OP_RATE;
                state_next = ica_pkg::ST_PRED;
            end
            ica_pkg::ST_PRED: begin
                cmd.op     = ica_pkg::OP_PRED;
                state_next = ica_pkg::ST_MULW;
            end
            ica_pkg::ST_MULW: begin
                cmd.op     = ica_pkg::OP_MULW;
                state_next = ica_pkg::ST_MULA;
            end
            ica_pkg::ST_MULA: begin
                cmd.op     = ica_pkg::OP_MULA;
                state_next = ica_pkg::ST_MIX;
            end
            ica_pkg::ST_MIX: begin
                cmd.op = ica_pkg::OP_MIX;
                if (axis_reg == ica_pkg::AXIS_ROLL) begin
                    axis_next  = ica_pkg::AXIS_PITCH;
                    state_next = ica_pkg::ST_RATE;
                end else begin
                    state_next = ica_pkg::ST_YRATE;
                end
            end
            ica_pkg::ST_YRATE: begin
                cmd.op     = ica_pkg::OP_YRATE;
                state_next = ica_pkg::ST_YAW;
            end
            ica_pkg::ST_YAW: begin
                cmd.op     = ica_pkg::OP_YAW;
                state_next = ica_pkg::ST_OUT;
            end
            ica_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = ica_pkg::OP_OUT;
                    state_next = ica_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ica_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ica_dpath.sv =====
// Datapath of the attitude estimator: root, CORDIC lanes, shared multiplier, tracks.
module ica_dpath (
    input  logic          aclk,
    input  logic          aresetn,
    input  ica_pkg::cmd_t cmd,
    output ica_pkg::status_t status,
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [15:0]   cfg_wdata,
    input  logic [95:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata
);

    localparam int LW = ica_pkg::LANE_W;
    localparam int AW = ica_pkg::ANG_W;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0] w_reg, sp_reg;
    logic signed [ica_pkg::PROD_W-1:0] prod_reg;
    logic signed [ica_pkg::PRED_W-1:0] pred_reg;
    logic signed [ica_pkg::PROD_W-1:0] acc_reg;
    logic [47:0] v_reg;
    logic [27:0] rem_reg;
    logic [23:0] root_reg;
    ica_pkg::lane_t roll_reg, pitch_reg;
    logic signed [ica_pkg::TRACK_W-1:0] rtrk_reg, ptrk_reg;
    logic [31:0] yaw_reg;
    logic m_tvalid_reg;
    logic [55:0] m_data_reg;

    logic signed [ica_pkg::PRED_W-1:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [ica_pkg::PROD_W-1:0] mul_p;

    function automatic ica_pkg::lane_t pre_rotate(logic signed [LW-1:0] x,
                                                   logic signed [LW-1:0] y);
        ica_pkg::lane_t l;
        l.x = x;
        l.y = y;
        l.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                l.x = y;
                l.y = -x;
                l.z = ica_pkg::QUARTER_TURN;
            end else begin
                l.x = -y;
                l.y = x;
                l.z = -ica_pkg::QUARTER_TURN;
            end
        end
        return l;
    endfunction

    function automatic ica_pkg::lane_t cordic_step(ica_pkg::lane_t l,
                                                    logic [ica_pkg::STEP_W-1:0] i);
        ica_pkg::lane_t r;
        logic signed [LW-1:0] xs, ys;
        logic signed [AW-1:0] a;
        xs = l.x >>> i;
        ys = l.y >>> i;
        a  = $signed({4'b0, ica_pkg::ATAN_TABLE[i]});
        r  = l;
        if (l.y > 0) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + a;
        end else if (l.y < 0) begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - a;
        end
        return r;
    endfunction

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ica_pkg::OP_SQ_A: begin
                mul_a = ica_pkg::PRED_W'(ay_reg);
                mul_b = 18'(ay_reg);
            end
            ica_pkg::OP_SQ_B: begin
                mul_a = ica_pkg::PRED_W'(az_reg);
                mul_b = 18'(az_reg);
            end
            ica_pkg::OP_RATE: begin
                mul_a = ica_pkg::PRED_W'((cmd.axis == ica_pkg::AXIS_PITCH) ? gy_reg : gx_reg);
                mul_b = $signed({2'b0, sp_reg});
            end
            ica_pkg::OP_YRATE: begin
                mul_a = ica_pkg::PRED_W'(gz_reg);
                mul_b = $signed({2'b0, sp_reg});
            end
            ica_pkg::OP_MULW: begin
                mul_a = pred_reg;
                mul_b = $signed({2'b0, w_reg});
            end
            ica_pkg::OP_MULA: begin
                mul_a = ica_pkg::PRED_W'((cmd.axis == ica_pkg::AXIS_PITCH)
                                         ? pitch_reg.z : roll_reg.z) <<< 7;
                mul_b = 18'sd65536 - $signed({2'b0, w_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = ica_pkg::PROD_W'(mul_a * mul_b);

    // Root step: bring down two bits, try subtracting 4*root+1
    logic [27:0] rem_sh, trial;
    assign rem_sh = {rem_reg[25:0], v_reg[47:46]};
    assign trial  = {2'b0, root_reg, 2'b01};

    // Blend result: round at 2^-23 and saturate to the track range
    logic signed [ica_pkg::MIX_W-1:0] mix_sum;
    logic signed [30:0] mix_q16;
    logic signed [ica_pkg::TRACK_W-1:0] mix_sat;
    assign mix_sum = ica_pkg::MIX_W'(acc_reg) + ica_pkg::MIX_W'(prod_reg)
                   + ica_pkg::MIX_W'(54'sd4194304);
    assign mix_q16 = 31'(mix_sum >>> 23);
    always_comb begin
        if (mix_q16 > 31'sd33554431) begin
            mix_sat = 26'sd33554431;
        end else if (mix_q16 < -31'sd33554432) begin
            mix_sat = -26'sd33554432;
        end else begin
            mix_sat = ica_pkg::TRACK_W'(mix_q16);
        end
    end

    logic signed [ica_pkg::YAW_W-1:0] yaw_sum, yaw_wrap;
    assign yaw_sum = $signed({2'b0, yaw_reg}) + ica_pkg::YAW_W'(prod_reg);
    always_comb begin
        if (yaw_sum < 0) begin
            yaw_wrap = yaw_sum + ica_pkg::YAW_MODULUS;
        end else if (yaw_sum >= ica_pkg::YAW_MODULUS) begin
            yaw_wrap = yaw_sum - ica_pkg::YAW_MODULUS;
        end else begin
            yaw_wrap = yaw_sum;
        end
    end

    logic signed [LW-1:0] pitch_y0;
    assign pitch_y0 = -(LW'(ax_reg) <<< 8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= ica_pkg::GYRO_WEIGHT_RESET;
            sp_reg       <= ica_pkg::SAMPLE_PERIOD_RESET;
            rtrk_reg     <= '0;
            ptrk_reg     <= '0;
            yaw_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ica_pkg::REG_GYRO_WEIGHT:   w_reg  <= cfg_wdata;
                    ica_pkg::REG_SAMPLE_PERIOD: sp_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op == ica_pkg::OP_MIX) begin
                if (cmd.axis == ica_pkg::AXIS_PITCH) begin
                    ptrk_reg <= mix_sat;
                end else begin
                    rtrk_reg <= mix_sat;
                end
            end
            if (cmd.op == ica_pkg::OP_YAW) begin
                yaw_reg <= 32'(yaw_wrap);
            end
            if (cmd.op == ica_pkg::OP_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            ica_pkg::OP_LOAD: begin
                ax_reg <= $signed(s_tdata[15:0]);
                ay_reg <= $signed(s_tdata[31:16]);
                az_reg <= $signed(s_tdata[47:32]);
                gx_reg <= $signed(s_tdata[63:48]);
                gy_reg <= $signed(s_tdata[79:64]);
                gz_reg <= $signed(s_tdata[95:80]);
            end
            ica_pkg::OP_SQ_A: prod_reg <= mul_p;
            ica_pkg::OP_SQ_B: begin
                v_reg    <= {prod_reg[31:0] + mul_p[31:0], 16'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ica_pkg::OP_ROOT: begin
                v_reg <= {v_reg[45:0], 2'b0};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            ica_pkg::OP_CINIT: begin
                roll_reg  <= pre_rotate(LW'(az_reg) <<< 8, LW'(ay_reg) <<< 8);
                pitch_reg <= pre_rotate($signed({4'b0, root_reg}), pitch_y0);
            end
            ica_pkg::OP_CORDIC: begin
                roll_reg  <= cordic_step(roll_reg, cmd.step);
                pitch_reg <= cordic_step(pitch_reg, cmd.step);
            end
            ica_pkg::OP_RATE:  prod_reg <= mul_p;
            ica_pkg::OP_YRATE: prod_reg <= mul_p;
            ica_pkg::OP_PRED: begin
                pred_reg <= (ica_pkg::PRED_W'((cmd.axis == ica_pkg::AXIS_PITCH)
                                              ? ptrk_reg : rtrk_reg) <<< 7)
                          + ica_pkg::PRED_W'(prod_reg);
            end
            ica_pkg::OP_MULW: prod_reg <= mul_p;
            ica_pkg::OP_MULA: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ica_pkg::OP_OUT: begin
                m_data_reg <= {3'b0, yaw_reg[31:15], ptrk_reg[25:8], rtrk_reg[25:8]};
            end
            default: ;
        endcase
    end

    assign status.in_valid = 1'b0;
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_data_reg;

endmodule
